/* hw/rtl/lspg_pkg.sv */
`timescale 1ns / 1ps

package lspg_pkg;

   localparam int MAX_PIXELS = 64;

   localparam int PIX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int PERIOD_W   = 16;
   localparam int STEP_W     = 11;
   localparam int COLOR_W    = 8;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // animation modes
   localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAINBOW = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CYCLE   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_GRAY    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANIM_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_COUNT  = 2'd2;

   localparam logic [MODE_W-1:0]   RESET_MODE   = MODE_NONE;
   localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd20;
   localparam logic [CNT_W-1:0]    RESET_COUNT  = 7'd10;

   localparam logic [STEP_W-1:0] STEP_LIMIT_PLAIN = 11'd256;
   localparam logic [STEP_W-1:0] STEP_LIMIT_CYCLE = 11'd1280;

   localparam logic [COLOR_W-1:0] WHEEL_THIRD      = 8'd85;
   localparam logic [COLOR_W-1:0] WHEEL_TWO_THIRDS = 8'd170;
   localparam logic [COLOR_W-1:0] COLOR_MAX        = 8'd255;

   // 256 / pixel count, one quotient bit per cycle
   localparam int DIV_W     = 9;
   localparam int DIV_CNT_W = 4;
   localparam logic [DIV_W-1:0]     DIV_DIVIDEND = 9'd256;
   localparam logic [DIV_CNT_W-1:0] DIV_MSB      = 4'(DIV_W - 1);

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic tick_accept;
      logic div_start;
      logic pixel_load;
      logic frame_adv;
   } cmd_type;

   typedef struct packed {
      logic frame_due;
      logic count_zero;
      logic div_done;
      logic out_free;
      logic pixel_last;
   } status_type;

   function automatic rgb_type wheel(input logic [COLOR_W-1:0] pos);
      rgb_type            c;
      logic [COLOR_W-1:0] q;
      logic [9:0]         q3;
      logic [COLOR_W-1:0] up;
      logic [COLOR_W-1:0] down;
      priority if (pos < WHEEL_THIRD) begin
         q = pos;
      end else if (pos < WHEEL_TWO_THIRDS) begin
         q = pos - WHEEL_THIRD;
      end else begin
         q = pos - WHEEL_TWO_THIRDS;
      end
      q3   = {2'b00, q} + {1'b0, q, 1'b0};
      up   = q3[COLOR_W-1:0];
      down = COLOR_MAX - up;
      priority if (pos < WHEEL_THIRD) begin
         c.red   = up;
         c.green = down;
         c.blue  = '0;
      end else if (pos < WHEEL_TWO_THIRDS) begin
         c.red   = down;
         c.green = '0;
         c.blue  = up;
      end else begin
         c.red   = '0;
         c.green = up;
         c.blue  = down;
      end
      return c;
   endfunction

endpackage

/* hw/rtl/lspg_if.sv */
`timescale 1ns / 1ps

interface lspg_req_if;
   logic valid;
   logic ready;
   logic ms_tick;

   modport source (output valid, output ms_tick, input ready);
   modport sink   (input valid, input ms_tick, output ready);
endinterface

interface lspg_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] pixel_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_pixel;

   modport source (output valid, output pixel_index, output red, output green,
                   output blue, output last_pixel, input ready);
   modport sink   (input valid, input pixel_index, input red, input green,
                   input blue, input last_pixel, output ready);
endinterface

/* hw/rtl/led_strip_pattern_generator_core.sv */
`timescale 1ns / 1ps

// LED strip pattern generator. Each transaction on req_ch carries one
// millisecond tick; after frame_period counted ticks (a period of zero acts as
// one) the block renders a frame of min(pixel_count, 64) pixels on rsp_ch,
// last_pixel marking the final one, in rainbow, rainbow cycle or plain gray
// mode, and mode none ignores ticks. A tick that renders nothing is accepted
// straight from idle. A rendering tick keeps req_ch.ready low through the frame:
// a 9-step shift-subtract unit first forms 256 / N for N pixels, then one pixel
// leaves the result register per cycle while rsp_ch.ready stays high. Any
// register write restarts the tick count; the user must write registers only
// while no frame is in flight, and the block itself does not enforce this.
module led_strip_pattern_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   lspg_req_if.sink                        req_ch,
   lspg_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [lspg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lspg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lspg_pkg::*;

   cmd_type    ctrl_cmd;
   status_type dp_status;

   lspg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   lspg_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_ms_tick (req_ch.ms_tick),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (ctrl_cmd),
      .status      (dp_status),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTH
   // a pixel is only loaded when the result register can take it
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.pixel_load |-> dp_status.out_free)
      else $error("pixel loaded over a pending result");

   // once a frame starts, no new tick is taken
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.div_start |=> !req_ch.ready)
      else $error("tick accepted while a frame is starting");

   // the frame counter moves only at the end of a frame, or on a due tick when the pixel count is zero
   assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.frame_adv |->
         (ctrl_cmd.pixel_load && dp_status.pixel_last) ||
         (ctrl_cmd.tick_accept && dp_status.frame_due && dp_status.count_zero))
      else $error("frame counter advanced outside a frame end");

   // a final pixel of a frame leaves the block idle for the next tick
   assert property (@(posedge clock) disable iff (reset)
      (ctrl_cmd.pixel_load && dp_status.pixel_last) |=> req_ch.ready)
      else $error("block not idle after the last pixel");
`endif

endmodule

/* hw/rtl/lspg_ctrl.sv */
`timescale 1ns / 1ps

module lspg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lspg_pkg::status_type status,
   output lspg_pkg::cmd_type    cmd
);
   import lspg_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.tick_accept = req_valid;
            if (req_valid && status.frame_due) begin
               if (status.count_zero) begin
                  cmd.frame_adv = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.pixel_load = 1'b1;
               if (status.pixel_last) begin
                  cmd.frame_adv = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lspg_datapath.sv */
`timescale 1ns / 1ps

module lspg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_ms_tick,
   input  logic                                csr_we,
   input  logic [lspg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lspg_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  lspg_pkg::cmd_type                   cmd,
   output lspg_pkg::status_type                status,
   lspg_rsp_if.source                          rsp_ch
);
   import lspg_pkg::*;

   // configuration and animation state
   logic [MODE_W-1:0]   mode_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [CNT_W-1:0]    pcount_ff;
   logic [PERIOD_W-1:0] tick_ff;
   logic [STEP_W-1:0]   step_ff;

   // divider
   logic                 div_busy_ff;
   logic                 div_done_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [CNT_W-1:0]     div_rem_ff;
   logic [COLOR_W-1:0]   div_q_ff;
   logic [CNT_W-1:0]     count_ff;

   // per-pixel position accumulator
   logic [CNT_W-1:0]   idx_ff;
   logic [COLOR_W-1:0] acc_q_ff;
   logic [PIX_W-1:0]   acc_r_ff;

   // result register
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_index_ff;
   rgb_type            rsp_color_ff;
   logic               rsp_last_ff;

   logic [PERIOD_W-1:0] period_eff;
   logic [PERIOD_W-1:0] tick_in;
   logic                frame_due;
   logic [CNT_W-1:0]    count_eff;
   logic                csr_hit;
   logic [CNT_W:0]      div_trial;
   logic                div_ge;
   logic [CNT_W-1:0]    div_rem_in;
   logic [CNT_W:0]      r_sum;
   logic                r_wrap;
   logic [COLOR_W-1:0]  base_pos;
   logic [COLOR_W-1:0]  wheel_pos;
   rgb_type             color;
   logic [STEP_W-1:0]   step_limit;

   assign period_eff = (period_ff == '0) ? PERIOD_W'(1) : period_ff;
   assign tick_in    = tick_ff + PERIOD_W'(1);
   assign frame_due  = req_ms_tick && (mode_ff != MODE_NONE) && (tick_in >= period_eff);
   assign count_eff  = (pcount_ff > CNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS) : pcount_ff;
   assign csr_hit    = csr_we && ((csr_index == CSR_ANIM_MODE) ||
                                  (csr_index == CSR_FRAME_PERIOD) ||
                                  (csr_index == CSR_PIXEL_COUNT));

   assign status.frame_due  = frame_due;
   assign status.count_zero = (count_eff == '0);
   assign status.div_done   = div_done_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ch.ready;
   assign status.pixel_last = ((idx_ff + CNT_W'(1)) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RESET_MODE;
         period_ff <= RESET_PERIOD;
         pcount_ff <= RESET_COUNT;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ANIM_MODE:    mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_FRAME_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_PIXEL_COUNT:  pcount_ff <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (csr_hit) begin
         tick_ff <= '0;
      end else if (cmd.tick_accept && req_ms_tick && (mode_ff != MODE_NONE)) begin
         tick_ff <= frame_due ? '0 : tick_in;
      end
   end

   assign step_limit = (mode_ff == MODE_CYCLE) ? STEP_LIMIT_CYCLE : STEP_LIMIT_PLAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.frame_adv) begin
         step_ff <= (step_ff >= step_limit) ? '0 : step_ff + STEP_W'(1);
      end
   end

   // restoring divide of 256 by the pixel count
   assign div_trial  = {div_rem_ff, DIV_DIVIDEND[div_cnt_ff]};
   assign div_ge     = div_trial >= {1'b0, count_ff};
   assign div_rem_in = div_ge ? CNT_W'(div_trial - {1'b0, count_ff}) : div_trial[CNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_done_ff <= div_busy_ff && (div_cnt_ff == '0);
         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
         end else if (div_cnt_ff == '0) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_cnt_ff <= DIV_MSB;
         div_rem_ff <= '0;
         div_q_ff   <= '0;
         count_ff   <= count_eff;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         div_rem_ff <= div_rem_in;
         div_q_ff   <= {div_q_ff[COLOR_W-2:0], div_ge};
      end
   end

   // floor(i*256/count) tracked as quotient plus remainder
   assign r_sum  = {2'b00, acc_r_ff} + {1'b0, div_rem_ff};
   assign r_wrap = r_sum >= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         idx_ff   <= '0;
         acc_q_ff <= '0;
         acc_r_ff <= '0;
      end else if (cmd.pixel_load) begin
         idx_ff <= idx_ff + CNT_W'(1);
         if (r_wrap) begin
            acc_r_ff <= PIX_W'(r_sum - {1'b0, count_ff});
            acc_q_ff <= acc_q_ff + div_q_ff + COLOR_W'(1);
         end else begin
            acc_r_ff <= PIX_W'(r_sum);
            acc_q_ff <= acc_q_ff + div_q_ff;
         end
      end
   end

   assign base_pos  = (mode_ff == MODE_CYCLE) ? acc_q_ff : COLOR_W'(idx_ff);
   assign wheel_pos = base_pos + step_ff[COLOR_W-1:0];

   always_comb begin
      if (mode_ff == MODE_GRAY) begin
         color.red   = step_ff[COLOR_W-1:0];
         color.green = step_ff[COLOR_W-1:0];
         color.blue  = step_ff[COLOR_W-1:0];
      end else begin
         color = wheel(wheel_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.pixel_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pixel_load) begin
         rsp_index_ff <= idx_ff[PIX_W-1:0];
         rsp_color_ff <= color;
         rsp_last_ff  <= status.pixel_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_index = rsp_index_ff;
   assign rsp_ch.red         = rsp_color_ff.red;
   assign rsp_ch.green       = rsp_color_ff.green;
   assign rsp_ch.blue        = rsp_color_ff.blue;
   assign rsp_ch.last_pixel  = rsp_last_ff;

endmodule
